@@ hdl/mhpq_pkg.sv @@
package mhpq_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int COORD_BITS_DEF = 10;
  localparam int COST_BITS_DEF  = 16;
  localparam int CNT_BITS       = 9;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_RELAX = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  cell_row;
    logic [9:0]  cell_col;
    logic [15:0] cell_cost;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        top_valid;
    logic [9:0]  top_row;
    logic [9:0]  top_col;
    logic [15:0] top_cost;
    logic [8:0]  entry_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_ROOT_RD,
    S_RESULT
  } state_t;

  // commands from controller to datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PUSH_WR,
    OP_POP_INIT,
    OP_UP_RD,
    OP_UP_STEP,
    OP_DN_RD,
    OP_DN_STEP,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_STEP,
    OP_SCAN_HIT,
    OP_ROOT_RD,
    OP_ROOT_PEEK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       up_done;
    logic       up_swap;
    logic       dn_done;
    logic       dn_swap;
    logic       scan_end;
    logic       scan_hit;
  } sts_t;

endpackage

@@ hdl/mhpq_datapath.sv @@
module mhpq_datapath #(
  parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = mhpq_pkg::COORD_BITS_DEF,
  parameter int COST_BITS  = mhpq_pkg::COST_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mhpq_pkg::in_word_t in_word,
  input  mhpq_pkg::cmd_t     cmd,
  output mhpq_pkg::sts_t     sts,
  output mhpq_pkg::out_word_t res_word
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = AW + 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [COST_BITS-1:0]  cost;
  } ent_t;

  ent_t mem [CAPACITY];
  ent_t rd_a_r, rd_b_r;
  ent_t cur_r, cur_nxt;
  ent_t in_ent;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] scan_r, scan_nxt;
  logic          we;
  logic          re;
  logic [AW-1:0] wa, ra_a, ra_b;
  ent_t          wd;
  logic [1:0]    kind_r;
  logic [CW-1:0] cnt_w;
  logic [PW-1:0] lidx, ridx;
  logic          l_ok, r_ok, l_lt, r_lt_l, r_lt_c;
  logic [AW-1:0] par;

  assign in_ent = '{row: in_word.cell_row[COORD_BITS-1:0],
                    col: in_word.cell_col[COORD_BITS-1:0],
                    cost: in_word.cell_cost[COST_BITS-1:0]};
  assign cnt_w = cnt_r;
  assign par   = AW'((pos_r - AW'(1)) >> 1);
  assign lidx  = PW'({pos_r, 1'b1});
  assign ridx  = PW'({pos_r, 1'b0}) + PW'(2);
  assign l_ok  = lidx < PW'(cnt_r);
  assign r_ok  = ridx < PW'(cnt_r);
  assign l_lt  = rd_a_r.cost < cur_r.cost;
  assign r_lt_l = rd_b_r.cost < rd_a_r.cost;
  assign r_lt_c = rd_b_r.cost < cur_r.cost;

  // status to controller
  always_comb begin
    sts.kind     = kind_r;
    sts.empty    = (cnt_r == '0);
    sts.full     = (cnt_r >= CW'(CAPACITY));
    sts.up_done  = (pos_r == '0);
    sts.up_swap  = rd_a_r.cost > cur_r.cost;
    sts.dn_done  = !l_ok;
    sts.dn_swap  = (l_ok && l_lt) || (r_ok && r_lt_c);
    sts.scan_end = scan_r >= PW'(cnt_r);
    sts.scan_hit = rd_a_r.row == cur_r.row && rd_a_r.col == cur_r.col &&
                   rd_a_r.cost > cur_r.cost;
  end

  // datapath next values and memory port control
  always_comb begin
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    scan_nxt = scan_r;
    we   = 1'b0;
    re   = 1'b0;
    wa   = pos_r;
    wd   = cur_r;
    ra_a = par;
    ra_b = AW'(ridx);
    unique case (cmd.op)
      mhpq_pkg::OP_LOAD: cur_nxt = in_ent;
      mhpq_pkg::OP_PUSH_WR: begin
        we = 1'b1;
        wa = AW'(cnt_r);
        pos_nxt = AW'(cnt_r);
        cnt_nxt = cnt_r + CW'(1);
      end
      mhpq_pkg::OP_POP_INIT: begin
        // last entry becomes the moving item, marked by scan at one
        re = 1'b1;
        ra_a = AW'(cnt_r - CW'(1));
        cnt_nxt = cnt_r - CW'(1);
        pos_nxt = '0;
        scan_nxt = PW'(1);
      end
      mhpq_pkg::OP_UP_RD: begin
        re = 1'b1;
        ra_a = par;
      end
      mhpq_pkg::OP_UP_STEP: begin
        // parent moves down, new item moves up
        we = 1'b1;
        wa = pos_r;
        wd = rd_a_r;
        pos_nxt = par;
      end
      mhpq_pkg::OP_DN_RD: begin
        re = 1'b1;
        ra_a = AW'(lidx);
        ra_b = AW'(ridx);
        scan_nxt = '0;
        if (pos_r == '0 && scan_r == PW'(1)) cur_nxt = rd_a_r;
      end
      mhpq_pkg::OP_DN_STEP: begin
        we = 1'b1;
        wa = pos_r;
        if (r_ok && (l_lt ? r_lt_l : r_lt_c)) begin
          wd = rd_b_r;
          pos_nxt = AW'(ridx);
        end else begin
          wd = rd_a_r;
          pos_nxt = AW'(lidx);
        end
      end
      mhpq_pkg::OP_SCAN_INIT: scan_nxt = '0;
      mhpq_pkg::OP_SCAN_RD: begin
        re = 1'b1;
        ra_a = AW'(scan_r);
      end
      mhpq_pkg::OP_SCAN_STEP: scan_nxt = scan_r + PW'(1);
      mhpq_pkg::OP_SCAN_HIT: pos_nxt = AW'(scan_r);
      mhpq_pkg::OP_ROOT_RD: begin
        we = 1'b1;
        re = 1'b1;
        wa = pos_r;
        ra_a = '0;
      end
      mhpq_pkg::OP_ROOT_PEEK: begin
        re = 1'b1;
        ra_a = '0;
      end
      default: ;
    endcase
  end

  // heap memory, one write and two registered reads held between reads
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rd_a_r <= (we && wa == ra_a) ? wd : mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    pos_r  <= pos_nxt;
    scan_r <= scan_nxt;
    cur_r  <= cur_nxt;
    if (cmd.op == mhpq_pkg::OP_LOAD) kind_r <= in_word.kind;
  end

  // result word, root held in read port a
  always_comb begin
    res_word = '0;
    res_word.status = cmd.status;
    res_word.top_valid = (cnt_w != '0);
    res_word.entry_count = 9'(cnt_w);
    if (cnt_w != '0) begin
      res_word.top_row  = 10'(rd_a_r.row);
      res_word.top_col  = 10'(rd_a_r.col);
      res_word.top_cost = 16'(rd_a_r.cost);
    end
  end

endmodule

@@ hdl/mhpq_ctrl.sv @@
module mhpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mhpq_pkg::sts_t sts,
  output mhpq_pkg::cmd_t cmd
);
  mhpq_pkg::state_t state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
      st_r    <= mhpq_pkg::ST_DONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.op    = mhpq_pkg::OP_NOP;
    cmd.status = st_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = mhpq_pkg::OP_LOAD;
          state_nxt = mhpq_pkg::S_DECIDE;
        end
      end
      mhpq_pkg::S_DECIDE: begin
        // operations that change nothing only read the root
        st_nxt = mhpq_pkg::ST_DONE;
        cmd.op = mhpq_pkg::OP_ROOT_PEEK;
        state_nxt = mhpq_pkg::S_RESULT;
        case (sts.kind)
          mhpq_pkg::KIND_PUSH: begin
            if (sts.full) st_nxt = mhpq_pkg::ST_FULL;
            else begin
              cmd.op = mhpq_pkg::OP_PUSH_WR;
              state_nxt = mhpq_pkg::S_UP_RD;
            end
          end
          mhpq_pkg::KIND_POP: begin
            if (sts.empty) st_nxt = mhpq_pkg::ST_EMPTY;
            else begin
              cmd.op = mhpq_pkg::OP_POP_INIT;
              state_nxt = mhpq_pkg::S_DN_RD;
            end
          end
          mhpq_pkg::KIND_RELAX: begin
            cmd.op = mhpq_pkg::OP_SCAN_INIT;
            state_nxt = mhpq_pkg::S_SCAN_RD;
          end
          default: ;
        endcase
      end
      mhpq_pkg::S_UP_RD: begin
        if (sts.up_done) state_nxt = mhpq_pkg::S_ROOT_RD;
        else begin
          cmd.op = mhpq_pkg::OP_UP_RD;
          state_nxt = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.op = mhpq_pkg::OP_UP_STEP;
          state_nxt = mhpq_pkg::S_UP_RD;
        end else state_nxt = mhpq_pkg::S_ROOT_RD;
      end
      mhpq_pkg::S_DN_RD: begin
        cmd.op = mhpq_pkg::OP_DN_RD;
        state_nxt = mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        if (!sts.dn_done && sts.dn_swap) begin
          cmd.op = mhpq_pkg::OP_DN_STEP;
          state_nxt = mhpq_pkg::S_DN_RD;
        end else state_nxt = mhpq_pkg::S_ROOT_RD;
      end
      mhpq_pkg::S_SCAN_RD: begin
        if (sts.scan_end) begin
          st_nxt = mhpq_pkg::ST_NO_MATCH;
          state_nxt = mhpq_pkg::S_RESULT;
          cmd.op = mhpq_pkg::OP_ROOT_PEEK;
        end else begin
          cmd.op = mhpq_pkg::OP_SCAN_RD;
          state_nxt = mhpq_pkg::S_SCAN_CMP;
        end
      end
      mhpq_pkg::S_SCAN_CMP: begin
        if (sts.scan_hit) begin
          cmd.op = mhpq_pkg::OP_SCAN_HIT;
          state_nxt = mhpq_pkg::S_UP_RD;
        end else begin
          cmd.op = mhpq_pkg::OP_SCAN_STEP;
          state_nxt = mhpq_pkg::S_SCAN_RD;
        end
      end
      mhpq_pkg::S_ROOT_RD: begin
        cmd.op = mhpq_pkg::OP_ROOT_RD;
        state_nxt = mhpq_pkg::S_RESULT;
      end
      mhpq_pkg::S_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = mhpq_pkg::S_IDLE;
      end
      default: state_nxt = mhpq_pkg::S_IDLE;
    endcase
  end

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == mhpq_pkg::S_DECIDE)
    else $error("accept without decode");

endmodule

@@ hdl/min_heap_priority_queue_unit.sv @@
// binary min-heap priority queue of grid cells keyed on cost
// input channel in_valid/in_ready carries one word: kind, row, column, cost
// kinds: push, pop root, relax (lower the cost of the first costlier match)
// output channel out_valid/out_ready returns one word per input: status,
// root after the operation and the entry count
// one word is handled at a time; in_ready is high only while idle
// push: write the entry at the end, then sift it up, reading and comparing a parent
// per level; pop: move the last entry to the root and sift it down, reading and
// comparing both children per level; relax: read and compare one entry at a time,
// then the sift-up as for push; each level or entry takes a read state and a compare
// state, set by the single heap memory with registered reads
// reset clears the entry count and control state; heap memory needs no clearing
// while out_ready is low the result word holds and no new word is taken
module min_heap_priority_queue_unit #(
  parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = mhpq_pkg::COORD_BITS_DEF,
  parameter int COST_BITS  = mhpq_pkg::COST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::out_word_t out_data
);
  mhpq_pkg::cmd_t cmd;
  mhpq_pkg::sts_t sts;

  // controller
  mhpq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  // datapath with heap memory
  mhpq_datapath #(
    .CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS), .COST_BITS(COST_BITS)
  ) u_dp (
    .clk, .rst_n, .in_word(in_data), .cmd, .sts, .res_word(out_data)
  );

endmodule

@@ tb/sv/mhpq_checker.sv @@
`timescale 1ns / 1ps

module mhpq_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  mhpq_pkg::in_word_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  mhpq_pkg::out_word_t          out_data,
  output int                           fail_count,
  output int                           pending_count
);
  localparam int DEPTH = mhpq_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [15:0] cost;
  } cell_t;

  cell_t               heap_model [DEPTH];
  int                  fill_model;
  mhpq_pkg::out_word_t root_queue [$];

  // exchange two heap slots
  function automatic void swap_slots(int a, int b);
    cell_t t;
    t = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = t;
  endfunction

  // climb while the parent is strictly costlier
  function automatic void climb(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_model[up].cost <= heap_model[pos].cost) break;
      swap_slots(pos, up);
      pos = up;
    end
  endfunction

  // fall towards the cheaper child, left first on ties
  function automatic void fall(int pos);
    int l, r, best;
    while (pos < fill_model) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < fill_model && heap_model[l].cost < heap_model[pos].cost) best = l;
      if (r < fill_model && heap_model[r].cost < heap_model[best].cost) best = r;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  // apply one word and build the expected root report
  function automatic mhpq_pkg::out_word_t heap_operation(mhpq_pkg::in_word_t w);
    mhpq_pkg::out_word_t o;
    cell_t               c;
    mhpq_pkg::status_t   st;
    st = mhpq_pkg::ST_DONE;
    c.row  = w.cell_row;
    c.col  = w.cell_col;
    c.cost = w.cell_cost;
    case (mhpq_pkg::kind_t'(w.kind))
      mhpq_pkg::KIND_PUSH: begin
        if (fill_model >= DEPTH) st = mhpq_pkg::ST_FULL;
        else begin
          heap_model[fill_model] = c;
          fill_model++;
          climb(fill_model - 1);
        end
      end
      mhpq_pkg::KIND_POP: begin
        if (fill_model == 0) st = mhpq_pkg::ST_EMPTY;
        else begin
          heap_model[0] = heap_model[fill_model - 1];
          fill_model--;
          fall(0);
        end
      end
      mhpq_pkg::KIND_RELAX: begin
        st = mhpq_pkg::ST_NO_MATCH;
        for (int i = 0; i < fill_model; i++) begin
          if (heap_model[i].row == c.row && heap_model[i].col == c.col &&
              heap_model[i].cost > c.cost) begin
            heap_model[i] = c;
            climb(i);
            st = mhpq_pkg::ST_DONE;
            break;
          end
        end
      end
      default: ;
    endcase
    o = '0;
    o.status = st;
    if (fill_model > 0) begin
      o.top_valid = 1'b1;
      o.top_row   = heap_model[0].row;
      o.top_col   = heap_model[0].col;
      o.top_cost  = heap_model[0].cost;
    end
    o.entry_count = fill_model[8:0];
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    mhpq_pkg::out_word_t e;
    if (!rst_n) begin
      fill_model = 0;
      fail_count = 0;
      root_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (root_queue.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          e = root_queue.pop_front();
          if (out_data.status != e.status)
            report("status", int'(out_data.status), int'(e.status));
          if (out_data.top_valid != e.top_valid)
            report("top_valid", int'(out_data.top_valid), int'(e.top_valid));
          if (out_data.top_row != e.top_row)
            report("top_row", int'(out_data.top_row), int'(e.top_row));
          if (out_data.top_col != e.top_col)
            report("top_col", int'(out_data.top_col), int'(e.top_col));
          if (out_data.top_cost != e.top_cost)
            report("top_cost", int'(out_data.top_cost), int'(e.top_cost));
          if (out_data.entry_count != e.entry_count)
            report("entry_count", int'(out_data.entry_count), int'(e.entry_count));
        end
      end
      if (in_valid && in_ready)
        root_queue.insert(root_queue.size(), heap_operation(in_data));
    end
    pending_count = root_queue.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 20000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mhpq_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mhpq_pkg::out_word_t out_data;
  int        fail_count;
  int        pending_count;
  int        idle_cycles;
  int        gap_left;
  int        burst_left;
  logic [9:0] hot_row [4];
  logic [9:0] hot_col [4];

  min_heap_priority_queue_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  mhpq_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern: long ready stretches and random stall runs
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'b0;
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (!rst_n) idle_cycles <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // present one word, with burst and gap idling, and wait for acceptance
  task automatic send_word(mhpq_pkg::kind_t k, logic [9:0] r, logic [9:0] c,
                           logic [15:0] cost);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      burst_left = $urandom_range(1, 30);
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{kind: k, cell_row: r, cell_col: c, cell_cost: cost};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until every expected result has come
  task automatic hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int              n;
    int              h;
    mhpq_pkg::kind_t k;
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    burst_left  = 0;
    for (int i = 0; i < 4; i++) begin
      hot_row[i] = 10'($urandom);
      hot_col[i] = 10'($urandom);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, extremes, ties, relax hit and miss, unused kind
    send_word(mhpq_pkg::KIND_POP, 10'd0, 10'd0, 16'd0);
    send_word(mhpq_pkg::KIND_RELAX, 10'd1, 10'd1, 16'd0);
    send_word(mhpq_pkg::KIND_NONE, 10'h3ff, 10'h3ff, 16'hffff);
    send_word(mhpq_pkg::KIND_PUSH, 10'h3ff, 10'h3ff, 16'hffff);
    send_word(mhpq_pkg::KIND_PUSH, 10'd0, 10'd0, 16'h0000);
    send_word(mhpq_pkg::KIND_PUSH, 10'd5, 10'd6, 16'd100);
    send_word(mhpq_pkg::KIND_PUSH, 10'd7, 10'd8, 16'd100);
    send_word(mhpq_pkg::KIND_PUSH, 10'd9, 10'd9, 16'd100);
    send_word(mhpq_pkg::KIND_RELAX, 10'h3ff, 10'h3ff, 16'hffff);
    send_word(mhpq_pkg::KIND_RELAX, 10'h3ff, 10'h3ff, 16'd3);
    send_word(mhpq_pkg::KIND_RELAX, 10'd7, 10'd8, 16'd0);
    send_word(mhpq_pkg::KIND_NONE, 10'h155, 10'h2aa, 16'h5555);
    for (int i = 0; i < 7; i++)
      send_word(mhpq_pkg::KIND_POP, 10'h2aa, 10'h155, 16'haaaa);

    // fill to capacity, push when full, then drain partly
    for (int i = 0; i < 257; i++)
      send_word(mhpq_pkg::KIND_PUSH, 10'($urandom), 10'($urandom), pick_cost());
    send_word(mhpq_pkg::KIND_RELAX, 10'($urandom), 10'($urandom), 16'd0);
    for (int i = 0; i < 200; i++) send_word(mhpq_pkg::KIND_POP, 10'd0, 10'd0, 16'd0);

    // hold off until every result is back
    hold_off();

    // random mix around a few hot cells so relax finds matches
    n = 0;
    while (n < 1400) begin
      h = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = mhpq_pkg::KIND_PUSH;
        4, 5, 6:    k = mhpq_pkg::KIND_POP;
        7, 8:       k = mhpq_pkg::KIND_RELAX;
        default:    k = mhpq_pkg::KIND_NONE;
      endcase
      if ($urandom_range(0, 2) != 0)
        send_word(k, hot_row[h], hot_col[h], pick_cost());
      else
        send_word(k, 10'($urandom), 10'($urandom), pick_cost());
      if (k != mhpq_pkg::KIND_NONE) n++;
      if (n == 700) hold_off();
    end

    // drain and settle
    hold_off();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
